// ===== hw/rtl/rsc_pkg.sv =====
// Shared types and constants for the rotor substitution cipher.
`default_nettype none

package rsc_pkg;

  // Alphabet and rotor count
  localparam int ALPHABET_SIZE = 26;
  localparam int NUM_ROTORS    = 3;
  localparam int LETTER_COUNT  = 26;
  localparam int LETTER_SPAN   = (ALPHABET_SIZE < LETTER_COUNT) ? ALPHABET_SIZE : LETTER_COUNT;

  // Symbol and rotor select widths
  localparam int SYM_W = $clog2(ALPHABET_SIZE);
  localparam int ROT_W = (NUM_ROTORS > 1) ? $clog2(NUM_ROTORS) : 1;

  // Request queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Action codes
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_CIPHER = 1'b1;

  // Character bases
  localparam logic [7:0] CHAR_LO_A = 8'h61;
  localparam logic [7:0] CHAR_UP_A = 8'h41;

  // Request kinds after classification
  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_LETTER,
    KIND_PASS
  } kind_t;

  // One classified request
  typedef struct packed {
    kind_t             kind;
    logic [ROT_W-1:0]  rotor;
    logic [SYM_W-1:0]  entry;
    logic [SYM_W-1:0]  value;
    logic [SYM_W-1:0]  sym;
    logic [7:0]        chr;
  } item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rsc_front.sv =====
// Front end: accepts requests, classifies them and pushes them into the queue.
`default_nettype none

module rsc_front (
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic         in_action,
  input  wire logic [1:0]   in_rotor_select,
  input  wire logic [4:0]   in_entry_index,
  input  wire logic [4:0]   in_entry_value,
  input  wire logic [7:0]   in_char_in,
  input  wire logic         q_full,
  output logic              push_valid,
  output rsc_pkg::item_t    push_item
);

  logic       load_ok;
  logic       is_lower;
  logic       is_upper;
  logic       val_sat;
  logic [7:0] base;
  logic [7:0] diff;

  // Check load target and letter ranges
  assign load_ok  = (in_rotor_select < rsc_pkg::NUM_ROTORS) &&
                    (in_entry_index < rsc_pkg::ALPHABET_SIZE);
  assign val_sat  = (in_entry_value > (rsc_pkg::ALPHABET_SIZE - 1));
  assign is_lower = (in_char_in >= rsc_pkg::CHAR_LO_A) &&
                    (in_char_in < (rsc_pkg::CHAR_LO_A + rsc_pkg::LETTER_SPAN));
  assign is_upper = (in_char_in >= rsc_pkg::CHAR_UP_A) &&
                    (in_char_in < (rsc_pkg::CHAR_UP_A + rsc_pkg::LETTER_SPAN));
  assign base     = is_lower ? rsc_pkg::CHAR_LO_A : rsc_pkg::CHAR_UP_A;
  assign diff     = in_char_in - base;

  // Build the classified request
  always_comb begin
    push_item.rotor = rsc_pkg::ROT_W'(in_rotor_select);
    push_item.entry = in_entry_index[rsc_pkg::SYM_W-1:0];
    push_item.value = val_sat ? rsc_pkg::SYM_W'(rsc_pkg::ALPHABET_SIZE - 1)
                              : in_entry_value[rsc_pkg::SYM_W-1:0];
    push_item.sym   = diff[rsc_pkg::SYM_W-1:0];
    if (in_action == rsc_pkg::ACT_LOAD) begin
      push_item.kind = rsc_pkg::KIND_LOAD;
      push_item.chr  = in_char_in;
    end else if (is_lower || is_upper) begin
      push_item.kind = rsc_pkg::KIND_LETTER;
      push_item.chr  = base;
    end else begin
      push_item.kind = rsc_pkg::KIND_PASS;
      push_item.chr  = in_char_in;
    end
  end

  // Accept while the queue has room; drop loads aimed outside the tables
  assign in_ready   = !q_full;
  assign push_valid = in_valid && !q_full && ((in_action == rsc_pkg::ACT_CIPHER) || load_ok);

endmodule

`default_nettype wire

// ===== hw/rtl/rsc_queue.sv =====
// Short request queue between the front end and the rotor back end.
`default_nettype none

module rsc_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push_valid,
  input  wire rsc_pkg::item_t push_item,
  output logic               full,
  input  wire logic          pop,
  output logic               pop_valid,
  output rsc_pkg::item_t     pop_item
);

  rsc_pkg::item_t                  slot_r [rsc_pkg::QUEUE_DEPTH];
  logic [rsc_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [rsc_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [rsc_pkg::QCNT_W-1:0]      count_r, count_nxt;
  logic                            do_push;
  logic                            do_pop;

  assign full      = (count_r == rsc_pkg::QCNT_W'(rsc_pkg::QUEUE_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_item  = slot_r[rd_ptr_r];
  assign do_push   = push_valid && !full;
  assign do_pop    = pop && pop_valid;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == rsc_pkg::QPTR_W'(rsc_pkg::QUEUE_DEPTH - 1)) ? '0
                   : wr_ptr_r + rsc_pkg::QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == rsc_pkg::QPTR_W'(rsc_pkg::QUEUE_DEPTH - 1)) ? '0
                   : rd_ptr_r + rsc_pkg::QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + rsc_pkg::QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - rsc_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Hold request payloads
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rsc_back.sv =====
// Back end: rotor tables, rotor offsets, substitution and output register.
`default_nettype none

module rsc_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_valid,
  input  wire rsc_pkg::item_t q_item,
  output logic                q_pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [7:0]          out_char_out
);

  localparam int SW = rsc_pkg::SYM_W;
  localparam int NR = rsc_pkg::NUM_ROTORS;

  logic [SW-1:0] table_r [NR][rsc_pkg::ALPHABET_SIZE];
  logic [SW-1:0] off_r   [NR];
  logic [SW-1:0] off_nxt [NR];
  logic [SW-1:0] x       [NR+1];
  logic [SW:0]   pos_sum [NR];
  logic [SW-1:0] pos     [NR];
  logic          carry   [NR+1];
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_char_r, out_char_nxt;
  logic          pop_load;
  logic          pop_letter;

  // Pop when the request makes no result or the output register frees up
  assign q_pop      = q_valid && ((q_item.kind == rsc_pkg::KIND_LOAD) || !out_valid_r || out_ready);
  assign pop_load   = q_pop && (q_item.kind == rsc_pkg::KIND_LOAD);
  assign pop_letter = q_pop && (q_item.kind == rsc_pkg::KIND_LETTER);

  // Write one table entry on a load
  always_ff @(posedge clk) begin
    if (pop_load) begin
      table_r[q_item.rotor][q_item.entry] <= q_item.value;
    end
  end

  // Pass the symbol through each rotor at its offset
  always_comb begin
    x[0] = q_item.sym;
    for (int r = 0; r < NR; r++) begin
      pos_sum[r] = {1'b0, x[r]} + {1'b0, off_r[r]};
      pos[r]     = (pos_sum[r] >= (SW+1)'(rsc_pkg::ALPHABET_SIZE))
                   ? SW'(pos_sum[r] - (SW+1)'(rsc_pkg::ALPHABET_SIZE))
                   : pos_sum[r][SW-1:0];
      x[r+1]     = table_r[r][pos[r]];
    end
  end

  // Step offsets like an odometer
  always_comb begin
    carry[0] = 1'b1;
    for (int r = 0; r < NR; r++) begin
      off_nxt[r] = off_r[r];
      carry[r+1] = 1'b0;
      if (carry[r]) begin
        if (off_r[r] == SW'(rsc_pkg::ALPHABET_SIZE - 1)) begin
          off_nxt[r] = '0;
          carry[r+1] = 1'b1;
        end else begin
          off_nxt[r] = off_r[r] + SW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < NR; r++) begin
        off_r[r] <= '0;
      end
    end else if (pop_letter) begin
      off_r <= off_nxt;
    end
  end

  // Load the output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (q_pop) begin
      unique case (q_item.kind)
        rsc_pkg::KIND_LETTER: begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = q_item.chr + 8'(x[NR]);
        end
        rsc_pkg::KIND_PASS: begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = q_item.chr;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_char_r <= out_char_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_char_out = out_char_r;

endmodule

`default_nettype wire

// ===== hw/rtl/rotor_substitution_cipher.sv =====
// Top level of the three-rotor substitution cipher.
//
//  channel  direction  handshake              payload
//  in       input      in_valid / in_ready    action, rotor_select, entry_index,
//                                             entry_value, char_in
//  out      output     out_valid / out_ready  char_out
//
// One request per cycle sustained while the output is not stalled; a cipher
// result goes from a queue slot, written at the taking edge, to the output
// register; the back end's whole rotor pass and offset step are combinational.
// Reset clears the rotor offsets, queue and output valid; tables stay unknown.
// in_ready drops only while the two-slot queue is full; loads drain even when
// the output is stalled.
`default_nettype none

module rotor_substitution_cipher (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       in_action,
  input  wire logic [1:0] in_rotor_select,
  input  wire logic [4:0] in_entry_index,
  input  wire logic [4:0] in_entry_value,
  input  wire logic [7:0] in_char_in,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_char_out
);

  logic           q_full;
  logic           push_valid;
  rsc_pkg::item_t push_item;
  logic           q_pop;
  logic           q_valid;
  rsc_pkg::item_t q_item;

  rsc_front u_front (
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_rotor_select (in_rotor_select),
    .in_entry_index  (in_entry_index),
    .in_entry_value  (in_entry_value),
    .in_char_in      (in_char_in),
    .q_full          (q_full),
    .push_valid      (push_valid),
    .push_item       (push_item)
  );

  rsc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_item   (q_item)
  );

  rsc_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char_out (out_char_out)
  );

`ifndef SYNTHESIS
  // A full queue must hold a request
  a_full_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> q_valid)
    else $error("queue reports full while empty");

  // A result-making request blocked by a stalled output stays queued
  a_blocked_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && (q_item.kind != rsc_pkg::KIND_LOAD) && out_valid && !out_ready)
    |=> q_valid)
    else $error("blocked request lost from queue");

  // The back end never pops a request that is not there
  a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for the three-rotor substitution cipher.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_REQS = 1500;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 20;

  // One input request as the driver presents it
  typedef struct packed {
    logic       action;
    logic [1:0] rotor_sel;
    logic [4:0] index;
    logic [4:0] value;
    logic [7:0] chr;
  } request_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       in_action = rsc_pkg::ACT_LOAD;
  logic [1:0] in_rotor_select = '0;
  logic [4:0] in_entry_index = '0;
  logic [4:0] in_entry_value = '0;
  logic [7:0] in_char_in = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_char_out;

  rotor_substitution_cipher DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_rotor_select (in_rotor_select),
    .in_entry_index  (in_entry_index),
    .in_entry_value  (in_entry_value),
    .in_char_in      (in_char_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_char_out    (out_char_out)
  );

  // Requests waiting to be driven, and cipher bytes waiting to come out
  request_t   pending_reqs[$];
  logic [7:0] expected_chars[$];

  // Predicted machine state
  logic [4:0] rotor_map[rsc_pkg::NUM_ROTORS][rsc_pkg::ALPHABET_SIZE];
  logic [4:0] rotor_pos[rsc_pkg::NUM_ROTORS];

  int total_reqs = 0;
  int sent_count = 0;
  int errors = 0;
  int n_loads = 0;
  int n_ignored = 0;
  int n_letters = 0;
  int n_passed = 0;
  int n_wraps = 0;
  bit pressure_done = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Traffic phase: both idle, roles swapped, then full rate
  function automatic int traffic_phase();
    if (sent_count < total_reqs / 3) return 0;
    if (sent_count < 2 * total_reqs / 3) return 1;
    return 2;
  endfunction

  function automatic int sender_idle_pct();
    case (traffic_phase())
      0: return 38;
      1: return 75;
      default: return 0;
    endcase
  endfunction

  function automatic int receiver_idle_pct();
    case (traffic_phase())
      0: return 75;
      1: return 38;
      default: return 0;
    endcase
  endfunction

  // Apply one accepted request to the predicted state; queue the byte it yields
  task automatic apply_request(input request_t req);
    int base;
    int sym;
    int slot;
    bit carry;
    if (req.action == rsc_pkg::ACT_LOAD) begin
      n_loads++;
      if (int'(req.rotor_sel) < rsc_pkg::NUM_ROTORS &&
          int'(req.index) < rsc_pkg::ALPHABET_SIZE) begin
        rotor_map[req.rotor_sel][req.index] =
          (int'(req.value) > rsc_pkg::ALPHABET_SIZE - 1) ?
          5'(rsc_pkg::ALPHABET_SIZE - 1) : req.value;
      end else begin
        n_ignored++;
      end
      return;
    end
    if (int'(req.chr) >= int'(rsc_pkg::CHAR_LO_A) &&
        int'(req.chr) < int'(rsc_pkg::CHAR_LO_A) + rsc_pkg::LETTER_SPAN)
      base = int'(rsc_pkg::CHAR_LO_A);
    else if (int'(req.chr) >= int'(rsc_pkg::CHAR_UP_A) &&
             int'(req.chr) < int'(rsc_pkg::CHAR_UP_A) + rsc_pkg::LETTER_SPAN)
      base = int'(rsc_pkg::CHAR_UP_A);
    else begin
      n_passed++;
      expected_chars.push_back(req.chr);
      return;
    end
    n_letters++;
    // Pass the symbol through each rotor at its current offset
    sym = int'(req.chr) - base;
    for (int r = 0; r < rsc_pkg::NUM_ROTORS; r++) begin
      slot = (sym + int'(rotor_pos[r])) % rsc_pkg::ALPHABET_SIZE;
      sym = int'(rotor_map[r][slot]);
    end
    expected_chars.push_back(8'(base + sym));
    // Advance the rotors like an odometer
    carry = 1'b1;
    for (int r = 0; r < rsc_pkg::NUM_ROTORS && carry; r++) begin
      if (int'(rotor_pos[r]) == rsc_pkg::ALPHABET_SIZE - 1) begin
        rotor_pos[r] = '0;
        if (r == 0) n_wraps++;
      end else begin
        rotor_pos[r] = rotor_pos[r] + 5'd1;
        carry = 1'b0;
      end
    end
  endtask

  function automatic request_t load_req(int sel, int idx, int val);
    request_t req;
    req.action = rsc_pkg::ACT_LOAD;
    req.rotor_sel = 2'(sel);
    req.index = 5'(idx);
    req.value = 5'(val);
    req.chr = 8'($urandom);
    return req;
  endfunction

  function automatic request_t cipher_req(int c);
    request_t req;
    req.action = rsc_pkg::ACT_CIPHER;
    req.rotor_sel = 2'($urandom);
    req.index = 5'($urandom);
    req.value = 5'($urandom);
    req.chr = 8'(c);
    return req;
  endfunction

  function automatic int random_letter();
    int base;
    base = $urandom_range(1) ? int'(rsc_pkg::CHAR_UP_A) : int'(rsc_pkg::CHAR_LO_A);
    return base + $urandom_range(rsc_pkg::LETTER_SPAN - 1);
  endfunction

  // Driver: present queued requests, hold each until taken
  always @(posedge clk) begin : drive
    request_t next_req;
    bit busy;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      busy = in_valid;
      if (in_valid && in_ready) begin
        apply_request({in_action, in_rotor_select, in_entry_index, in_entry_value,
                       in_char_in});
        sent_count <= sent_count + 1;
        busy = 1'b0;
      end
      if (!busy) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= sender_idle_pct()) begin
          next_req = pending_reqs.pop_front();
          in_action       <= next_req.action;
          in_rotor_select <= next_req.rotor_sel;
          in_entry_index  <= next_req.index;
          in_entry_value  <= next_req.value;
          in_char_in      <= next_req.chr;
          in_valid        <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result, throttle out_ready, stall once for a long stretch
  always @(posedge clk) begin : observe
    logic [7:0] want;
    int hold_left;
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          $error("char_out: expected none, actual %02h", out_char_out);
          errors++;
        end else begin
          want = expected_chars.pop_front();
          if (out_char_out !== want) begin
            $error("char_out: expected %02h, actual %02h", want, out_char_out);
            errors++;
          end
        end
      end
      if (!pressure_done && traffic_phase() == 2) begin
        hold_left = HOLD_CYCLES;
        pressure_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= receiver_idle_pct());
      end
    end
  end

  // Stimulus and end of run
  initial begin : stimulus
    int sel;
    int idx;
    int roll;
    // Write every table entry before any letter reads one
    for (int r = 0; r < rsc_pkg::NUM_ROTORS; r++)
      for (int i = 0; i < rsc_pkg::ALPHABET_SIZE; i++)
        pending_reqs.push_back(load_req(r, i, $urandom_range(31)));

    // Ignored loads, saturation, and overwrite of a wiring entry
    pending_reqs.push_back(load_req(3, 4, 9));
    pending_reqs.push_back(load_req(1, 31, 31));
    pending_reqs.push_back(load_req(2, 26, 3));
    pending_reqs.push_back(load_req(0, 0, 31));
    pending_reqs.push_back(load_req(2, 25, 26));
    pending_reqs.push_back(load_req(1, 13, 0));
    // Letter extremes in both cases
    pending_reqs.push_back(cipher_req("a"));
    pending_reqs.push_back(cipher_req("z"));
    pending_reqs.push_back(cipher_req("A"));
    pending_reqs.push_back(cipher_req("Z"));
    pending_reqs.push_back(cipher_req("m"));
    // Bytes just outside the letter ranges and byte extremes pass through
    pending_reqs.push_back(cipher_req(8'h60));
    pending_reqs.push_back(cipher_req(8'h7b));
    pending_reqs.push_back(cipher_req(8'h40));
    pending_reqs.push_back(cipher_req(8'h5b));
    pending_reqs.push_back(cipher_req(8'h00));
    pending_reqs.push_back(cipher_req(8'hff));
    pending_reqs.push_back(cipher_req(8'h80));
    pending_reqs.push_back(cipher_req(8'h20));
    pending_reqs.push_back(load_req(0, 25, 12));
    pending_reqs.push_back(cipher_req("q"));

    // Random mix: mostly letters, some raw bytes, some loads (a quarter from the full range)
    for (int n = 0; n < RANDOM_REQS; n++) begin
      roll = $urandom_range(99);
      if (roll < 20) begin
        if ($urandom_range(3) == 0) begin
          sel = $urandom_range(3);
          idx = $urandom_range(31);
        end else begin
          sel = $urandom_range(rsc_pkg::NUM_ROTORS - 1);
          idx = $urandom_range(rsc_pkg::ALPHABET_SIZE - 1);
        end
        pending_reqs.push_back(load_req(sel, idx, $urandom_range(31)));
      end else if (roll < 32) begin
        pending_reqs.push_back(cipher_req($urandom_range(255)));
      end else begin
        pending_reqs.push_back(cipher_req(random_letter()));
      end
    end
    total_reqs = pending_reqs.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: everything sent and every result seen
    while (pending_reqs.size() != 0 || in_valid || expected_chars.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d loads (%0d ignored), %0d letters, %0d pass-through bytes,",
             n_loads, n_ignored, n_letters, n_passed);
    $display("%0d first-rotor wraps, with a %0d-cycle output stall.",
             n_wraps, HOLD_CYCLES);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/rsc_pkg.sv
hw/rtl/rsc_front.sv
hw/rtl/rsc_queue.sv
hw/rtl/rsc_back.sv
hw/rtl/rotor_substitution_cipher.sv
verif/tb.sv
